/* src/vks_pkg.sv */
// ----------------------------------------------------------------------------
// vks_pkg
// Shared types, widths and constants for the kinematic step estimator.
// ----------------------------------------------------------------------------
package vks_pkg;

   // fixed point and field widths
   localparam int FRAC_BITS        = 16;
   localparam int POS_BITS         = 32;
   localparam int CORDIC_STEPS_DEF = 16;
   localparam int ATAN_ENTRIES     = 24;
   localparam int ATAN_IDX_BITS    = 5;
   localparam int THR_W            = 18;
   localparam int STEER_W          = 19;
   localparam int DT_IN_W          = 20;
   localparam int DT_W             = 13;
   localparam int WB_W             = 20;
   localparam int LIM_W            = 21;
   localparam int GAIN_W           = 18;
   localparam int HEAD_W           = 19;
   localparam int SPEED_W          = 21;
   localparam int CSR_ADDR_W       = 3;
   localparam int CSR_DATA_W       = 21;
   localparam int MUL_W            = 28;
   localparam int PROD_W           = 2 * MUL_W;
   localparam int RND_W            = PROD_W - FRAC_BITS;
   localparam int ANG_W            = 22;
   localparam int TRIG_W           = FRAC_BITS + 2;
   localparam int CZ_W             = 36;
   localparam int CXY_W            = 34;
   localparam int NUM_W            = 40;
   localparam int DEN_W            = 22;
   localparam int QUO_W            = FRAC_BITS + 2;

   // scalar constants in Q(FRAC_BITS)
   localparam int ONE         = 1 << FRAC_BITS;
   localparam int DT_MIN      = (ONE + 500) / 1000;
   localparam int DT_MAX      = (ONE + 5) / 10;
   localparam int STEER_MIN   = (ONE + 50) / 100;
   localparam int SPEED_MIN   = (ONE + 5) / 10;
   localparam int YAW_MAX     = 2 * ONE;
   localparam int START_SPEED = ONE / 2;

   // angle constants, Q30
   localparam longint PI30_L   = 64'sd3373259426;
   localparam longint PI_Q_L   = (PI30_L + (64'sd1 <<< (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
   localparam int     ANG_SHIFT = 30 - FRAC_BITS;
   localparam logic signed [CZ_W-1:0] PI30      = 36'sd3373259426;
   localparam logic signed [CZ_W-1:0] HALF_PI30 = 36'sd1686629713;
   localparam logic signed [CZ_W-1:0] TWO_PI30  = 36'sd6746518852;
   localparam logic signed [CXY_W-1:0] GAIN30   = 34'sd652032874;

   // configuration register indexes
   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_WHEEL_BASE   = 3'd0,
      CSR_ACCEL_LIMIT  = 3'd1,
      CSR_DECEL_LIMIT  = 3'd2,
      CSR_ROLLING_DRAG = 3'd3,
      CSR_AIR_DRAG     = 3'd4,
      CSR_SPEED_LIMIT  = 3'd5,
      CSR_STEER_GAIN   = 3'd6
   } csr_idx_type;

   // datapath operations, one per controller step
   typedef enum logic [4:0] {
      OP_NONE, OP_LOAD, OP_INIT, OP_MSQ, OP_MDRAG, OP_MTHR, OP_ACC, OP_MDV,
      OP_V, OP_MDIST, OP_DIST, OP_MX, OP_X, OP_Y, OP_MANG, OP_CANG,
      OP_MDEN, OP_MNUM, OP_DIVGO, OP_MDH, OP_H, OP_OUT
   } dp_op_type;

   // controller states
   typedef enum logic [4:0] {
      S_IDLE, S_START, S_DRAG, S_THR, S_ACC, S_MDV, S_V, S_MDIST, S_CW1,
      S_MX, S_X, S_Y, S_MANG, S_CANG, S_CW2, S_MDEN, S_MNUM, S_DIVGO,
      S_DW, S_MDH, S_H, S_OUT
   } ctrl_state_type;

   // cordic unit phases
   typedef enum logic [1:0] {
      CP_IDLE, CP_REDUCE, CP_ROTATE
   } cordic_phase_type;

   typedef struct packed {
      dp_op_type op;
   } dp_cmd_type;

   typedef struct packed {
      logic started;
      logic turn;
      logic cordic_done;
      logic div_done;
   } dp_status_type;

   // arctangent of 2^-i, Q30
   function automatic logic [31:0] atan_q30(input logic [ATAN_IDX_BITS-1:0] idx);
      logic [31:0] val;
      unique case (idx)
         5'd0:    val = 32'd843314857;
         5'd1:    val = 32'd497837829;
         5'd2:    val = 32'd263043837;
         5'd3:    val = 32'd133525159;
         5'd4:    val = 32'd67021687;
         5'd5:    val = 32'd33543516;
         5'd6:    val = 32'd16775851;
         5'd7:    val = 32'd8388437;
         5'd8:    val = 32'd4194283;
         5'd9:    val = 32'd2097149;
         5'd10:   val = 32'd1048576;
         5'd11:   val = 32'd524288;
         5'd12:   val = 32'd262144;
         5'd13:   val = 32'd131072;
         5'd14:   val = 32'd65536;
         5'd15:   val = 32'd32768;
         5'd16:   val = 32'd16384;
         5'd17:   val = 32'd8192;
         5'd18:   val = 32'd4096;
         5'd19:   val = 32'd2048;
         5'd20:   val = 32'd1024;
         5'd21:   val = 32'd512;
         5'd22:   val = 32'd256;
         5'd23:   val = 32'd128;
         default: val = 32'd0;
      endcase
      return val;
   endfunction

endpackage

/* src/vks_cordic.sv */
// ----------------------------------------------------------------------------
// vks_cordic
// Iterative rotation-mode cordic: sine and cosine of a Q16 angle.
// ----------------------------------------------------------------------------
module vks_cordic
   import vks_pkg::*;
#(
   parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic signed [ANG_W-1:0]  ang,
   output logic                     done,
   output logic signed [TRIG_W-1:0] sin_q,
   output logic signed [TRIG_W-1:0] cos_q
);

   cordic_phase_type phase_ff, phase_in;
   logic [CZ_W-1:0]           zmag_ff, zmag_in;
   logic                      zneg_ff, zneg_in;
   logic signed [CZ_W-1:0]    z_ff, z_in;
   logic signed [CXY_W-1:0]   x_ff, x_in, y_ff, y_in;
   logic                      flip_ff, flip_in;
   logic [ATAN_IDX_BITS-1:0]  idx_ff, idx_in;
   logic                      done_ff, done_in;
   logic [ANG_W-1:0]          ang_mag;
   logic signed [CZ_W-1:0]    zs, zw, at;
   logic signed [CXY_W-1:0]   xs, ys, xf, yf, xr, yr;
   logic                      red_more, last_step;

   assign ang_mag   = ang[ANG_W-1] ? ANG_W'(-ang) : ANG_W'(ang);
   assign red_more  = (zmag_ff >= $unsigned(TWO_PI30));
   assign last_step = (idx_ff == ATAN_IDX_BITS'(CORDIC_STEPS - 1));

   // next phase
   always_comb begin
      phase_in = phase_ff;
      if (start) begin
         phase_in = CP_REDUCE;
      end else begin
         unique case (phase_ff)
            CP_IDLE:   phase_in = CP_IDLE;
            CP_REDUCE: phase_in = red_more ? CP_REDUCE : CP_ROTATE;
            CP_ROTATE: phase_in = last_step ? CP_IDLE : CP_ROTATE;
            default:   phase_in = CP_IDLE;
         endcase
      end
   end

   // angle reduction to +-pi/2 and the rotation steps
   always_comb begin
      zmag_in = zmag_ff;
      zneg_in = zneg_ff;
      z_in    = z_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      flip_in = flip_ff;
      idx_in  = idx_ff;
      done_in = done_ff;
      zs      = zneg_ff ? -$signed(zmag_ff) : $signed(zmag_ff);
      zw      = zs;
      xs      = x_ff >>> idx_ff;
      ys      = y_ff >>> idx_ff;
      at      = $signed(CZ_W'(atan_q30(idx_ff)));
      if (zs > PI30) begin
         zw = zs - TWO_PI30;
      end else if (zs < -PI30) begin
         zw = zs + TWO_PI30;
      end
      if (start) begin
         zmag_in = CZ_W'(ang_mag) << ANG_SHIFT;
         zneg_in = ang[ANG_W-1];
         done_in = 1'b0;
      end else begin
         unique case (phase_ff)
            CP_IDLE: begin
            end
            CP_REDUCE: begin
               if (red_more) begin
                  zmag_in = zmag_ff - $unsigned(TWO_PI30);
               end else begin
                  x_in    = GAIN30;
                  y_in    = '0;
                  idx_in  = '0;
                  flip_in = 1'b0;
                  z_in    = zw;
                  if (zw > HALF_PI30) begin
                     z_in    = zw - PI30;
                     flip_in = 1'b1;
                  end else if (zw < -HALF_PI30) begin
                     z_in    = zw + PI30;
                     flip_in = 1'b1;
                  end
               end
            end
            CP_ROTATE: begin
               if (z_ff >= 0) begin
                  x_in = x_ff - ys;
                  y_in = y_ff + xs;
                  z_in = z_ff - at;
               end else begin
                  x_in = x_ff + ys;
                  y_in = y_ff - xs;
                  z_in = z_ff + at;
               end
               idx_in  = idx_ff + 1'b1;
               done_in = last_step;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= CP_IDLE;
         done_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         done_ff  <= done_in;
      end
      zmag_ff <= zmag_in;
      zneg_ff <= zneg_in;
      z_ff    <= z_in;
      x_ff    <= x_in;
      y_ff    <= y_in;
      flip_ff <= flip_in;
      idx_ff  <= idx_in;
   end

   // undo the half-turn fold and round Q30 to Q16
   assign xf    = flip_ff ? -x_ff : x_ff;
   assign yf    = flip_ff ? -y_ff : y_ff;
   assign xr    = xf + CXY_W'(1 << (ANG_SHIFT - 1));
   assign yr    = yf + CXY_W'(1 << (ANG_SHIFT - 1));
   assign cos_q = $signed(xr[ANG_SHIFT +: TRIG_W]);
   assign sin_q = $signed(yr[ANG_SHIFT +: TRIG_W]);
   assign done  = done_ff;

endmodule

/* src/vks_div.sv */
// ----------------------------------------------------------------------------
// vks_div
// Restoring divider for the yaw rate, truncating and clamped to +-2 rad/s.
// ----------------------------------------------------------------------------
module vks_div
   import vks_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic signed [NUM_W-1:0]  num,
   input  logic signed [DEN_W-1:0]  den,
   output logic                     done,
   output logic signed [HEAD_W-1:0] rate
);

   localparam int CNT_W = $clog2(QUO_W);

   logic [NUM_W-1:0] rem_ff, rem_in, ds_ff, ds_in;
   logic [QUO_W-1:0] q_ff, q_in, q_clamp;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in, done_ff, done_in, neg_ff, neg_in;
   logic [NUM_W-1:0] nmag, dmag;
   logic             ge, ovf;

   assign nmag = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
   assign dmag = den[DEN_W-1] ? NUM_W'(DEN_W'(-den)) : NUM_W'(DEN_W'(den));
   assign ovf  = (nmag >= (dmag << QUO_W));
   assign ge   = (rem_ff >= ds_ff);

   // start sets up or short-cuts, then one quotient bit per cycle
   always_comb begin
      rem_in  = rem_ff;
      ds_in   = ds_ff;
      q_in    = q_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = done_ff;
      neg_in  = neg_ff;
      if (start) begin
         neg_in = num[NUM_W-1] ^ den[DEN_W-1];
         rem_in = nmag;
         ds_in  = dmag << (QUO_W - 1);
         cnt_in = CNT_W'(QUO_W - 1);
         q_in   = '0;
         if (nmag == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else if (ovf) begin
            q_in    = QUO_W'(YAW_MAX);
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            busy_in = 1'b1;
            done_in = 1'b0;
         end
      end else if (busy_ff) begin
         rem_in = ge ? rem_ff - ds_ff : rem_ff;
         q_in   = {q_ff[QUO_W-2:0], ge};
         ds_in  = ds_ff >> 1;
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      ds_ff  <= ds_in;
      q_ff   <= q_in;
      cnt_ff <= cnt_in;
      neg_ff <= neg_in;
   end

   // clamp and sign
   assign q_clamp = (q_ff > QUO_W'(YAW_MAX)) ? QUO_W'(YAW_MAX) : q_ff;
   assign rate    = neg_ff ? -$signed({1'b0, q_clamp}) : $signed({1'b0, q_clamp});
   assign done    = done_ff;

endmodule

/* src/vks_dp.sv */
// ----------------------------------------------------------------------------
// vks_dp
// Datapath: configuration, estimate state, shared multiplier, cordic, divider.
// ----------------------------------------------------------------------------
module vks_dp
   import vks_pkg::*;
#(
   parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_we,
   input  logic [CSR_ADDR_W-1:0]       csr_addr,
   input  logic [CSR_DATA_W-1:0]       csr_wdata,
   input  logic signed [THR_W-1:0]     throttle,
   input  logic signed [STEER_W-1:0]   steer_angle,
   input  logic [DT_IN_W-1:0]          elapsed_time,
   input  dp_cmd_type                  cmd,
   output dp_status_type               status,
   output logic signed [POS_BITS-1:0]  pos_x,
   output logic signed [POS_BITS-1:0]  pos_y,
   output logic signed [HEAD_W-1:0]    heading,
   output logic [SPEED_W-1:0]          speed,
   output logic                        first_tick
);

   localparam logic signed [POS_BITS:0] POS_HI = (POS_BITS+1)'((64'sd1 <<< (POS_BITS-1)) - 1);
   localparam logic signed [POS_BITS:0] POS_LO = -POS_HI - 1;
   localparam logic signed [HEAD_W:0]   PI_Q   = (HEAD_W+1)'(PI_Q_L);

   // configuration registers
   logic [WB_W-1:0]   wheel_base_ff;
   logic [LIM_W-1:0]  accel_limit_ff, decel_limit_ff, rolling_drag_ff;
   logic [LIM_W-1:0]  air_drag_ff, speed_limit_ff;
   logic [GAIN_W-1:0] steer_gain_ff;

   // item and estimate registers
   logic signed [THR_W-1:0]    thr_ff;
   logic signed [STEER_W-1:0]  steer_ff;
   logic [DT_W-1:0]            dt_ff, dt_in;
   logic signed [POS_BITS-1:0] est_x_ff, est_y_ff, pos_in;
   logic signed [HEAD_W-1:0]   est_h_ff, h_in;
   logic [SPEED_W-1:0]         est_v_ff, v_in;
   logic                       started_ff;
   logic                       tick_first_ff;
   logic signed [PROD_W-1:0]   raw_ff, rsum;
   logic signed [33:0]         drag_ff;
   logic signed [LIM_W+1:0]    acc_ff, acc_in;
   logic signed [DT_IN_W-1:0]  dist_ff;
   logic signed [DEN_W-1:0]    den_ff;

   // result registers
   logic signed [POS_BITS-1:0] out_x_ff, out_y_ff;
   logic signed [HEAD_W-1:0]   out_h_ff;
   logic [SPEED_W-1:0]         out_v_ff;
   logic                       out_first_ff;

   logic signed [MUL_W-1:0]    mul_a, mul_b;
   logic                       mul_en;
   logic signed [RND_W-1:0]    rnd;
   logic signed [LIM_W+20:0]   acc_raw;
   logic signed [LIM_W+2:0]    v_sum;
   logic signed [POS_BITS:0]   pos_sum;
   logic signed [HEAD_W:0]     h_sum;
   logic signed [ANG_W-1:0]    cordic_ang;
   logic signed [TRIG_W-1:0]   sin_q, cos_q;
   logic signed [HEAD_W-1:0]   rate;
   logic                       cordic_done, div_done, cordic_start, div_start;

   // rounded product of the last multiplication
   assign rsum = raw_ff + PROD_W'(1 << (FRAC_BITS - 1));
   assign rnd  = $signed(rsum[PROD_W-1:FRAC_BITS]);

   // operand selection for the shared multiplier
   always_comb begin
      mul_a  = '0;
      mul_b  = '0;
      mul_en = 1'b1;
      unique case (cmd.op)
         OP_MSQ: begin
            mul_a = $signed(MUL_W'(est_v_ff));
            mul_b = $signed(MUL_W'(est_v_ff));
         end
         OP_MDRAG: begin
            mul_a = $signed(MUL_W'(air_drag_ff));
            mul_b = MUL_W'(rnd);
         end
         OP_MTHR: begin
            mul_a = MUL_W'(thr_ff);
            mul_b = $signed(MUL_W'(accel_limit_ff));
         end
         OP_MDV: begin
            mul_a = MUL_W'(acc_ff);
            mul_b = $signed(MUL_W'(dt_ff));
         end
         OP_MDIST: begin
            mul_a = $signed(MUL_W'(est_v_ff));
            mul_b = $signed(MUL_W'(dt_ff));
         end
         OP_MX: begin
            mul_a = MUL_W'(dist_ff);
            mul_b = MUL_W'(cos_q);
         end
         OP_X: begin
            mul_a = MUL_W'(dist_ff);
            mul_b = MUL_W'(sin_q);
         end
         OP_MANG: begin
            mul_a = MUL_W'(steer_ff);
            mul_b = $signed(MUL_W'(steer_gain_ff));
         end
         OP_MDEN: begin
            mul_a = MUL_W'(cos_q);
            mul_b = $signed(MUL_W'(wheel_base_ff));
         end
         OP_MNUM: begin
            mul_a = $signed(MUL_W'(est_v_ff));
            mul_b = MUL_W'(sin_q);
         end
         OP_MDH: begin
            mul_a = MUL_W'(rate);
            mul_b = $signed(MUL_W'(dt_ff));
         end
         default: mul_en = 1'b0;
      endcase
   end

   // time step clamp
   always_comb begin
      if (elapsed_time < DT_IN_W'(DT_MIN)) begin
         dt_in = DT_W'(DT_MIN);
      end else if (elapsed_time > DT_IN_W'(DT_MAX)) begin
         dt_in = DT_W'(DT_MAX);
      end else begin
         dt_in = DT_W'(elapsed_time);
      end
   end

   // acceleration: throttle term minus drags, clamped to the limits
   always_comb begin
      acc_raw = (LIM_W+21)'(rnd) - $signed((LIM_W+21)'(rolling_drag_ff))
                - (LIM_W+21)'(drag_ff);
      if (acc_raw > 0) begin
         acc_in = (acc_raw > $signed((LIM_W+21)'(accel_limit_ff)))
                  ? $signed((LIM_W+2)'(accel_limit_ff)) : (LIM_W+2)'(acc_raw);
      end else if (acc_raw < -$signed((LIM_W+21)'(decel_limit_ff))) begin
         acc_in = -$signed((LIM_W+2)'(decel_limit_ff));
      end else begin
         acc_in = (LIM_W+2)'(acc_raw);
      end
   end

   // speed integration, clamped to 0..speed_limit
   always_comb begin
      v_sum = $signed((LIM_W+3)'(est_v_ff)) + (LIM_W+3)'(rnd);
      if (v_sum < 0) begin
         v_in = '0;
      end else if (v_sum > $signed((LIM_W+3)'(speed_limit_ff))) begin
         v_in = speed_limit_ff;
      end else begin
         v_in = SPEED_W'(v_sum);
      end
   end

   // saturating position step, x on OP_X and y on OP_Y
   always_comb begin
      pos_sum = (cmd.op == OP_X) ? (POS_BITS+1)'(est_x_ff) : (POS_BITS+1)'(est_y_ff);
      pos_sum = pos_sum + (POS_BITS+1)'(rnd);
      if (pos_sum > POS_HI) begin
         pos_in = POS_BITS'(POS_HI);
      end else if (pos_sum < POS_LO) begin
         pos_in = POS_BITS'(POS_LO);
      end else begin
         pos_in = POS_BITS'(pos_sum);
      end
   end

   // heading integration with wrap to +-pi
   always_comb begin
      h_sum = (HEAD_W+1)'(est_h_ff) + (HEAD_W+1)'(rnd);
      if (h_sum > PI_Q) begin
         h_sum = h_sum - (PI_Q <<< 1);
      end
      if (h_sum < -PI_Q) begin
         h_sum = h_sum + (PI_Q <<< 1);
      end
      h_in = HEAD_W'(h_sum);
   end

   assign cordic_start = (cmd.op == OP_V) || (cmd.op == OP_CANG);
   assign cordic_ang   = (cmd.op == OP_V) ? ANG_W'(est_h_ff) : ANG_W'(rnd);
   assign div_start    = (cmd.op == OP_DIVGO);

   vks_cordic #(
      .CORDIC_STEPS (CORDIC_STEPS)
   ) u_cordic (
      .clock (clock),
      .reset (reset),
      .start (cordic_start),
      .ang   (cordic_ang),
      .done  (cordic_done),
      .sin_q (sin_q),
      .cos_q (cos_q)
   );

   vks_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (NUM_W'(raw_ff)),
      .den   (den_ff),
      .done  (div_done),
      .rate  (rate)
   );

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         wheel_base_ff   <= WB_W'(9830);
         accel_limit_ff  <= LIM_W'(196608);
         decel_limit_ff  <= LIM_W'(262144);
         rolling_drag_ff <= LIM_W'(6554);
         air_drag_ff     <= LIM_W'(3277);
         speed_limit_ff  <= LIM_W'(131072);
         steer_gain_ff   <= GAIN_W'(52429);
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_WHEEL_BASE:   wheel_base_ff   <= WB_W'(csr_wdata);
            CSR_ACCEL_LIMIT:  accel_limit_ff  <= csr_wdata;
            CSR_DECEL_LIMIT:  decel_limit_ff  <= csr_wdata;
            CSR_ROLLING_DRAG: rolling_drag_ff <= csr_wdata;
            CSR_AIR_DRAG:     air_drag_ff     <= csr_wdata;
            CSR_SPEED_LIMIT:  speed_limit_ff  <= csr_wdata;
            CSR_STEER_GAIN:   steer_gain_ff   <= GAIN_W'(csr_wdata);
            default: begin
            end
         endcase
      end
   end

   // estimate state
   always_ff @(posedge clock) begin
      if (reset) begin
         started_ff <= 1'b0;
         est_x_ff   <= '0;
         est_y_ff   <= '0;
         est_h_ff   <= '0;
         est_v_ff   <= '0;
      end else begin
         unique case (cmd.op)
            OP_INIT: begin
               started_ff <= 1'b1;
               est_x_ff   <= '0;
               est_y_ff   <= '0;
               est_h_ff   <= '0;
               est_v_ff   <= SPEED_W'(START_SPEED);
            end
            OP_V:    est_v_ff <= v_in;
            OP_X:    est_x_ff <= pos_in;
            OP_Y:    est_y_ff <= pos_in;
            OP_H:    est_h_ff <= h_in;
            default: begin
            end
         endcase
      end
   end

   // working registers and results
   always_ff @(posedge clock) begin
      if (mul_en) begin
         raw_ff <= mul_a * mul_b;
      end
      unique case (cmd.op)
         OP_LOAD: begin
            thr_ff        <= throttle;
            steer_ff      <= steer_angle;
            dt_ff         <= dt_in;
            tick_first_ff <= 1'b0;
         end
         OP_MTHR: drag_ff <= 34'(rnd);
         OP_ACC:  acc_ff  <= acc_in;
         OP_DIST: dist_ff <= DT_IN_W'(rnd);
         OP_MNUM: den_ff  <= DEN_W'(rnd);
         OP_OUT: begin
            out_x_ff     <= est_x_ff;
            out_y_ff     <= est_y_ff;
            out_h_ff     <= est_h_ff;
            out_v_ff     <= est_v_ff;
            out_first_ff <= tick_first_ff;
         end
         OP_INIT: tick_first_ff <= 1'b1;
         default: begin
         end
      endcase
   end

   // status back to the controller
   assign status.started     = started_ff;
   assign status.turn        = ((steer_ff > STEER_W'(STEER_MIN)) ||
                                (steer_ff < -STEER_W'(STEER_MIN))) &&
                               (est_v_ff > SPEED_W'(SPEED_MIN));
   assign status.cordic_done = cordic_done;
   assign status.div_done    = div_done;

   assign pos_x      = out_x_ff;
   assign pos_y      = out_y_ff;
   assign heading    = out_h_ff;
   assign speed      = out_v_ff;
   assign first_tick = out_first_ff;

endmodule

/* src/vks_ctrl.sv */
// ----------------------------------------------------------------------------
// vks_ctrl
// Sequencer for one tick: orders the datapath steps and owns the handshakes.
// ----------------------------------------------------------------------------
module vks_ctrl
   import vks_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   ctrl_state_type state_ff, state_in;
   logic           rsp_tvalid_ff, rsp_tvalid_in;
   logic           out_free, accept;

   assign out_free = !rsp_tvalid_ff || rsp_tready;
   assign accept   = req_tvalid && (state_ff == S_IDLE);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:  if (accept) state_in = S_START;
         S_START: state_in = status.started ? S_DRAG : S_OUT;
         S_DRAG:  state_in = S_THR;
         S_THR:   state_in = S_ACC;
         S_ACC:   state_in = S_MDV;
         S_MDV:   state_in = S_V;
         S_V:     state_in = S_MDIST;
         S_MDIST: state_in = S_CW1;
         S_CW1:   if (status.cordic_done) state_in = S_MX;
         S_MX:    state_in = S_X;
         S_X:     state_in = S_Y;
         S_Y:     state_in = status.turn ? S_MANG : S_OUT;
         S_MANG:  state_in = S_CANG;
         S_CANG:  state_in = S_CW2;
         S_CW2:   if (status.cordic_done) state_in = S_MDEN;
         S_MDEN:  state_in = S_MNUM;
         S_MNUM:  state_in = S_DIVGO;
         S_DIVGO: state_in = S_DW;
         S_DW:    if (status.div_done) state_in = S_MDH;
         S_MDH:   state_in = S_H;
         S_H:     state_in = S_OUT;
         S_OUT:   if (out_free) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // datapath command per state
   always_comb begin
      cmd.op = OP_NONE;
      unique case (state_ff)
         S_IDLE:  cmd.op = accept ? OP_LOAD : OP_NONE;
         S_START: cmd.op = status.started ? OP_MSQ : OP_INIT;
         S_DRAG:  cmd.op = OP_MDRAG;
         S_THR:   cmd.op = OP_MTHR;
         S_ACC:   cmd.op = OP_ACC;
         S_MDV:   cmd.op = OP_MDV;
         S_V:     cmd.op = OP_V;
         S_MDIST: cmd.op = OP_MDIST;
         S_CW1:   cmd.op = OP_DIST;
         S_MX:    cmd.op = OP_MX;
         S_X:     cmd.op = OP_X;
         S_Y:     cmd.op = OP_Y;
         S_MANG:  cmd.op = OP_MANG;
         S_CANG:  cmd.op = OP_CANG;
         S_CW2:   cmd.op = OP_NONE;
         S_MDEN:  cmd.op = OP_MDEN;
         S_MNUM:  cmd.op = OP_MNUM;
         S_DIVGO: cmd.op = OP_DIVGO;
         S_DW:    cmd.op = OP_NONE;
         S_MDH:   cmd.op = OP_MDH;
         S_H:     cmd.op = OP_H;
         S_OUT:   cmd.op = out_free ? OP_OUT : OP_NONE;
         default: cmd.op = OP_NONE;
      endcase
   end

   // result valid: set when the result register loads, cleared when taken
   always_comb begin
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      if (state_ff == S_OUT && out_free) begin
         rsp_tvalid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;

   // checks
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input taken twice for one tick");

   a_cordic_ready_x: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_MX |-> status.cordic_done)
      else $error("position step before heading cordic finished");

   a_cordic_ready_den: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_MDEN |-> status.cordic_done)
      else $error("yaw denominator before steering cordic finished");

   a_div_ready: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_MDH |-> status.div_done)
      else $error("heading step before yaw divide finished");

   a_out_free: assert property (@(posedge clock) disable iff (reset)
      cmd.op == OP_OUT |-> (!rsp_tvalid_ff || rsp_tready))
      else $error("result register overwritten while pending");

endmodule

/* src/vehicle_kinematic_step.sv */
// ----------------------------------------------------------------------------
// vehicle_kinematic_step
// Kinematic bicycle model state estimator, one pose update per tick.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one tick (throttle, steering angle, elapsed time). The
//   block takes a tick only when idle; req_tready is low while it works.
//   rsp_* returns one transaction per tick: position, heading, speed in
//   tdata, first_tick in tuser.
//   Path per tick: the first tick after reset only initializes the state;
//   a later tick runs the heading cordic, and with a turn also the
//   steering cordic and the yaw divide. A large steering angle adds
//   reduction steps to the steering cordic; a zero numerator or an
//   oversized quotient cuts the divide short. One tick is in flight at
//   a time and the block returns to idle between ticks, so a new tick
//   is taken only after the last one is through.
//   Reset (synchronous) restores the register defaults and clears the
//   estimate; the next tick only initializes the state.
//   A stalled receiver holds the result in the output register; the next
//   tick is still accepted and completes up to its result, then waits.
//   csr_* writes a register at each clock with csr_we high; write only
//   while no tick is in flight.
// ----------------------------------------------------------------------------
module vehicle_kinematic_step
   import vks_pkg::*;
#(
   parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [63:0]           req_tdata,   // throttle, steer_angle, elapsed_time
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [103:0]          rsp_tdata,   // pos_x, pos_y, heading, speed
   output logic [0:0]            rsp_tuser,   // first_tick
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   dp_cmd_type                 cmd;
   dp_status_type              status;
   logic signed [POS_BITS-1:0] pos_x, pos_y;
   logic signed [HEAD_W-1:0]   heading;
   logic [SPEED_W-1:0]         speed;
   logic                       first_tick;

   vks_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   vks_dp #(
      .CORDIC_STEPS (CORDIC_STEPS)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .csr_we       (csr_we),
      .csr_addr     (csr_addr),
      .csr_wdata    (csr_wdata),
      .throttle     ($signed(req_tdata[17:0])),
      .steer_angle  ($signed(req_tdata[36:18])),
      .elapsed_time (req_tdata[56:37]),
      .cmd          (cmd),
      .status       (status),
      .pos_x        (pos_x),
      .pos_y        (pos_y),
      .heading      (heading),
      .speed        (speed),
      .first_tick   (first_tick)
   );

   // result packing, first field lowest
   assign rsp_tdata = {speed, heading, pos_y, pos_x};
   assign rsp_tuser = first_tick;

endmodule

/* dv/vks_checker.sv */
// ----------------------------------------------------------------------------
// vks_checker
// Watches the tick, result and register ports of the kinematic step
// estimator. Keeps its own copy of the pose estimate and registers, predicts
// each result and compares it field by field with what the block returns.
// ----------------------------------------------------------------------------
module vks_checker
   import vks_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [63:0]           req_tdata,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [103:0]          rsp_tdata,
   input  logic [0:0]            rsp_tuser,
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int                    pending,
   output int                    fail_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic signed [31:0]   pos_x;
      logic signed [31:0]   pos_y;
      logic signed [18:0]   heading;
      logic [20:0]          speed;
      logic                 first_tick;
   } pose_type;

   localparam longint ONE_L    = longint'(ONE);
   localparam longint TWO_PI_L = 64'sd6746518852;
   localparam longint PI_L     = 64'sd3373259426;
   localparam longint HPI_L    = 64'sd1686629713;
   localparam longint GAIN_L   = 64'sd652032874;

   longint arctan_tbl [0:23] = '{
      843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
      16775851, 8388437, 4194283, 2097149, 1048576, 524288,
      262144, 131072, 65536, 32768, 16384, 8192,
      4096, 2048, 1024, 512, 256, 128};

   // register copies and estimate
   longint wheel_base, accel_lim, decel_lim, roll_drag, air_coef, top_speed, steer_gain;
   longint est_x, est_y, est_head, est_spd;
   bit     is_started;

   pose_type pose_q[$];
   int       mismatches;

   assign pending    = pose_q.size();
   assign fail_count = mismatches;

   // arithmetic shift rounding toward minus infinity
   function automatic longint shr_floor(longint v, int s);
      if (v >= 0) return v >>> s;
      return -(((-v) + ((64'sd1 <<< s) - 1)) >>> s);
   endfunction

   function automatic longint qmul(longint a, longint b);
      return shr_floor(a * b + (ONE_L >>> 1), FRAC_BITS);
   endfunction

   function automatic longint clamp_pos(longint v);
      longint hi;
      longint lo;
      hi = (64'sd1 <<< (POS_BITS - 1)) - 1;
      lo = -hi - 1;
      return v > hi ? hi : (v < lo ? lo : v);
   endfunction

   // rotation-mode cordic with quadrant fold
   task automatic trig(input longint ang, output longint s, output longint c);
      longint z;
      longint x;
      longint y;
      longint nx;
      bit     flip;
      z = (ang * (64'sd1 <<< ANG_SHIFT)) % TWO_PI_L;
      x = GAIN_L;
      y = 0;
      flip = 0;
      if (z > PI_L) z -= TWO_PI_L;
      if (z < -PI_L) z += TWO_PI_L;
      if (z > HPI_L) begin
         z -= PI_L;
         flip = 1;
      end else if (z < -HPI_L) begin
         z += PI_L;
         flip = 1;
      end
      for (int i = 0; i < CORDIC_STEPS_DEF && i < 24; i++) begin
         if (z >= 0) begin
            nx = x - shr_floor(y, i);
            y  = y + shr_floor(x, i);
            z -= arctan_tbl[i];
         end else begin
            nx = x + shr_floor(y, i);
            y  = y - shr_floor(x, i);
            z += arctan_tbl[i];
         end
         x = nx;
      end
      if (flip) begin
         x = -x;
         y = -y;
      end
      c = shr_floor(x + (64'sd1 <<< (ANG_SHIFT - 1)), ANG_SHIFT);
      s = shr_floor(y + (64'sd1 <<< (ANG_SHIFT - 1)), ANG_SHIFT);
   endtask

   // advance the estimate by one tick
   task automatic advance_pose(input logic [63:0] tick, output pose_type p);
      longint thr, steer, dt, acc, v, travel, s, c, num, den, rate, h, pi_q;
      p.first_tick = 0;
      pi_q = PI_Q_L;
      if (!is_started) begin
         est_x = 0; est_y = 0; est_head = 0;
         est_spd = START_SPEED;
         is_started = 1;
         p.first_tick = 1;
      end else begin
         thr   = longint'(signed'(tick[17:0]));
         steer = longint'(signed'(tick[36:18]));
         dt    = longint'(tick[56:37]);
         if (dt < DT_MIN) dt = DT_MIN;
         if (dt > DT_MAX) dt = DT_MAX;
         acc = qmul(thr, accel_lim) - roll_drag - qmul(air_coef, qmul(est_spd, est_spd));
         if (acc > 0) begin
            if (acc > accel_lim) acc = accel_lim;
         end else if (acc < -decel_lim) begin
            acc = -decel_lim;
         end
         v = est_spd + qmul(acc, dt);
         if (v < 0) v = 0;
         if (v > top_speed) v = top_speed;
         est_spd = v;
         travel = qmul(v, dt);
         trig(est_head, s, c);
         est_x = clamp_pos(est_x + qmul(travel, c));
         est_y = clamp_pos(est_y + qmul(travel, s));
         // turn only above both thresholds
         if ((steer > STEER_MIN || steer < -STEER_MIN) && v > SPEED_MIN) begin
            trig(qmul(steer, steer_gain), s, c);
            num = v * s;
            den = qmul(c, wheel_base);
            if (den == 0) begin
               rate = num > 0 ? YAW_MAX : (num < 0 ? -YAW_MAX : 0);
            end else begin
               rate = num / den;
               if (rate > YAW_MAX) rate = YAW_MAX;
               if (rate < -YAW_MAX) rate = -YAW_MAX;
            end
            h = est_head + qmul(rate, dt);
            if (h > pi_q) h -= 2 * pi_q;
            if (h < -pi_q) h += 2 * pi_q;
            est_head = h;
         end
      end
      p.pos_x   = est_x[31:0];
      p.pos_y   = est_y[31:0];
      p.heading = est_head[18:0];
      p.speed   = est_spd[20:0];
   endtask

   task automatic report(input string field, input longint exp_v, input longint act_v);
      mismatches++;
      if (mismatches <= 10)
         $display("mismatch %s: expected %0d got %0d at %0t", field, exp_v, act_v, $realtime);
   endtask

   // monitor all three ports at the rising edge
   always @(posedge clock) begin
      pose_type exp_p;
      pose_type act_p;
      if (reset) begin
         wheel_base = 9830; accel_lim = 196608; decel_lim = 262144;
         roll_drag = 6554; air_coef = 3277; top_speed = 131072; steer_gain = 52429;
         est_x = 0; est_y = 0; est_head = 0; est_spd = 0;
         is_started = 0;
         pose_q.delete();
         mismatches = 0;
      end else begin
         // result transaction, compared before a new tick is predicted
         if (rsp_tvalid && rsp_tready) begin
            act_p.pos_x      = rsp_tdata[31:0];
            act_p.pos_y      = rsp_tdata[63:32];
            act_p.heading    = rsp_tdata[82:64];
            act_p.speed      = rsp_tdata[103:83];
            act_p.first_tick = rsp_tuser[0];
            if (pose_q.size() == 0) begin
               report("unexpected result", 0, 1);
            end else begin
               exp_p = pose_q.pop_front();
               if (act_p.pos_x !== exp_p.pos_x) report("pos_x", exp_p.pos_x, act_p.pos_x);
               if (act_p.pos_y !== exp_p.pos_y) report("pos_y", exp_p.pos_y, act_p.pos_y);
               if (act_p.heading !== exp_p.heading)
                  report("heading", exp_p.heading, act_p.heading);
               if (act_p.speed !== exp_p.speed) report("speed", exp_p.speed, act_p.speed);
               if (act_p.first_tick !== exp_p.first_tick)
                  report("first_tick", exp_p.first_tick, act_p.first_tick);
            end
         end
         // tick transaction
         if (req_tvalid && req_tready) begin
            advance_pose(req_tdata, exp_p);
            pose_q.insert(pose_q.size(), exp_p);
         end
         // register write
         if (csr_we) begin
            case (csr_idx_type'(csr_addr))
               CSR_WHEEL_BASE:   wheel_base = longint'(csr_wdata[19:0]);
               CSR_ACCEL_LIMIT:  accel_lim  = longint'(csr_wdata[20:0]);
               CSR_DECEL_LIMIT:  decel_lim  = longint'(csr_wdata[20:0]);
               CSR_ROLLING_DRAG: roll_drag  = longint'(csr_wdata[20:0]);
               CSR_AIR_DRAG:     air_coef   = longint'(csr_wdata[20:0]);
               CSR_SPEED_LIMIT:  top_speed  = longint'(csr_wdata[20:0]);
               CSR_STEER_GAIN:   steer_gain = longint'(csr_wdata[17:0]);
               default: ;
            endcase
         end
      end
   end

endmodule

/* dv/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Stimulus for the kinematic step estimator: directed ticks at the field
// extremes and turn thresholds, then random ticks under several register
// settings and idling patterns. The checker module predicts and compares.
// ----------------------------------------------------------------------------
module testbench;
   import vks_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int ITEMS_PER_PHASE = 120;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [63:0]           req_tdata;   // throttle, steer_angle, elapsed_time
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [103:0]          rsp_tdata;   // pos_x, pos_y, heading, speed
   logic [0:0]            rsp_tuser;   // first_tick
   logic                  csr_we;
   logic [CSR_ADDR_W-1:0] csr_addr;
   logic [CSR_DATA_W-1:0] csr_wdata;
   int                    pending;
   int                    fail_count;
   int                    send_idle_pct;
   int                    recv_idle_pct;

   vehicle_kinematic_step uut (.*);

   vks_checker checker_i (.*);

   initial begin
      clock = 0;
      forever #1 clock = ~clock;
   end

   // receiver backpressure
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
   end

   // one tick transaction, with an optional gap first
   task automatic send_tick(input logic [17:0] thr, input logic [18:0] steer,
                            input logic [19:0] dt);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= {7'd0, dt, steer, thr};
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic drain();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (100) @(negedge clock);
   endtask

   task automatic write_regs(input logic [20:0] vals [0:6]);
      for (int i = 0; i < 7; i++) begin
         @(negedge clock);
         csr_we    <= 1'b1;
         csr_addr  <= csr_idx_type'(i);
         csr_wdata <= vals[i];
      end
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic random_tick();
      logic [17:0] thr;
      logic [18:0] steer;
      logic [19:0] dt;
      int          r;
      r = $urandom_range(0, 9);
      thr   = (r < 8) ? 18'($signed($urandom_range(0, 131072)) - 65536) : 18'($urandom);
      steer = (r < 7) ? 19'($signed($urandom_range(0, 411774)) - 205887) : 19'($urandom);
      if (r == 3) steer = $urandom_range(0, 1) ? 19'(STEER_MIN) : -19'(STEER_MIN);
      dt    = (r < 8) ? 20'($urandom_range(0, 8000)) : 20'($urandom);
      send_tick(thr, steer, dt);
   endtask

   initial begin
      logic [20:0] regs [0:6];
      reset = 1; req_tvalid = 0; req_tdata = '0; rsp_tready = 0;
      csr_we = 0; csr_addr = CSR_WHEEL_BASE; csr_wdata = '0;
      send_idle_pct = 0; recv_idle_pct = 0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // directed: first tick ignores its fields, then extremes and thresholds
      send_tick(18'h1ffff, 19'h3ffff, 20'hfffff);
      send_tick(18'h10000, 19'd0, 20'd0);
      send_tick(18'h1ffff, 19'd205887, 20'hfffff);
      send_tick(18'h20000, -19'sd205887, 20'd65);
      send_tick(18'h3ffff, 19'h40000, 20'd6554);
      send_tick(18'h10000, 19'(STEER_MIN), 20'd3000);
      send_tick(18'h10000, -19'(STEER_MIN), 20'd3000);
      send_tick(18'h10000, 19'(STEER_MIN + 1), 20'd6553);
      send_tick(-18'sd65536, -19'(STEER_MIN + 1), 20'd6555);
      send_tick(18'h30000, 19'h2aaaa, 20'h55555);
      send_tick(18'h0ffff, 19'h15555, 20'haaaaa);
      drain();

      // steering near a quarter turn with a short wheelbase: zero divisor
      regs = '{21'd655, 21'd1048576, 21'd0, 21'd0, 21'd0, 21'd1048576, 21'd131072};
      write_regs(regs);
      for (int i = 0; i < 12; i++)
         send_tick(18'h10000, (i % 2) ? 19'd51472 : -19'sd51472, 20'd6554);
      drain();

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: regs = '{21'hfffff, 21'h1fffff, 21'h1fffff, 21'h1fffff, 21'h1fffff,
                        21'h1fffff, 21'h3ffff};
            1: regs = '{21'd655, 21'd0, 21'd0, 21'd0, 21'd0, 21'd0, 21'd0};
            2: regs = '{21'd9830, 21'd196608, 21'd262144, 21'd6554, 21'd3277,
                        21'd131072, 21'd52429};
            default: for (int k = 0; k < 7; k++) regs[k] = 21'($urandom);
         endcase
         write_regs(regs);
         send_idle_pct = (phase == 0) ? 37 : (phase == 1) ? 83 : 0;
         recv_idle_pct = (phase == 0) ? 83 : (phase == 1) ? 37 : 0;
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            // hold off until every result is back
            if (n == ITEMS_PER_PHASE / 2) begin
               @(negedge clock);
               req_tvalid <= 1'b0;
               while (pending != 0) @(negedge clock);
            end
            random_tick();
         end
         drain();
      end

      if (fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   // run limit
   initial begin
      #2000000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule

/* vehicle_kinematic_step.f */
src/vks_pkg.sv
src/vks_cordic.sv
src/vks_div.sv
src/vks_dp.sv
src/vks_ctrl.sv
src/vehicle_kinematic_step.sv
dv/vks_checker.sv
dv/testbench.sv
